/* rtl/core/sliding_window_average_u16_macros.svh */
// assertion helpers shared by the rtl modules
`ifndef SLIDING_WINDOW_AVERAGE_U16_MACROS_SVH
`define SLIDING_WINDOW_AVERAGE_U16_MACROS_SVH

// same-cycle implication, checked out of reset
`define SWA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swa assertion failed");

// next-cycle implication, checked out of reset
`define SWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swa assertion failed");

`endif

/* rtl/core/swa_pkg.sv */
package swa_pkg;

  localparam int WINDOW_MAX_DEF = 32;
  localparam int SAMPLE_W       = 16;
  localparam int AVG_W          = 24;
  localparam int FILL_W         = 8;
  localparam int CFG_W          = 8;
  localparam int FRAC_W         = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic cfg_write;   // clamp and store window, restart the window
    logic cap_sample;  // latch the accepted sample
    logic pass_load;   // pass-through: quotient register takes sample * 256
    logic update;      // ring/sum/slot/count update and divider init
    logic div_step;    // one restoring division step
    logic load_out;    // move quotient and count into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pass_mode;   // window still zero, nothing written yet
    logic div_last;    // this division step is the final one
  } status_t;

endpackage

/* rtl/core/swa_ctrl.sv */
`include "sliding_window_average_u16_macros.svh"

module swa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  swa_pkg::status_t sts,
  output swa_pkg::cmd_t    cmd
);

  swa_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    cfg_ready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      swa_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cfg_ready = 1'b1;
        if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
        end else if (in_valid) begin
          cmd.cap_sample = 1'b1;
          if (sts.pass_mode) begin
            cmd.pass_load = 1'b1;
            state_nxt     = swa_pkg::ST_DONE;
          end else begin
            state_nxt = swa_pkg::ST_UPDATE;
          end
        end
        // a config request has priority; hold off the sample that cycle
        if (cfg_valid) begin
          in_ready = 1'b0;
        end
      end
      swa_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = swa_pkg::ST_DIV;
      end
      swa_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = swa_pkg::ST_DONE;
        end
      end
      swa_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = swa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swa_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `SWA_ASSERT_NEXT(a_pass_skips_div, clk, rst_n,
    in_valid && in_ready && sts.pass_mode, state_r == swa_pkg::ST_DONE)
  `SWA_ASSERT_NEXT(a_load_shows_valid, clk, rst_n, cmd.load_out, out_valid_r)
  `SWA_ASSERT_NOW(a_no_overwrite, clk, rst_n,
    cmd.load_out && out_valid_r, out_ready)

endmodule

/* rtl/core/swa_dp.sv */
`include "sliding_window_average_u16_macros.svh"

module swa_dp #(
  parameter int WINDOW_MAX = swa_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [swa_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [swa_pkg::CFG_W-1:0]    cfg_window_size,
  input  swa_pkg::cmd_t                cmd,
  output swa_pkg::status_t             sts,
  output logic [swa_pkg::AVG_W-1:0]    out_average_q8,
  output logic [swa_pkg::FILL_W-1:0]   out_fill_count
);

  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W  = swa_pkg::SAMPLE_W + CNT_W;
  localparam int DW     = SUM_W + swa_pkg::FRAC_W;
  localparam int STEP_W = $clog2(DW);

  logic [swa_pkg::SAMPLE_W-1:0] ring [WINDOW_MAX];
  logic [swa_pkg::SAMPLE_W-1:0] rd_data_r;
  logic [swa_pkg::SAMPLE_W-1:0] sample_r;

  logic [CNT_W-1:0]  window_r, window_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DW-1:0]     quot_r;
  logic [CNT_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;

  logic [swa_pkg::AVG_W-1:0]  avg_r;
  logic [swa_pkg::FILL_W-1:0] fill_r;

  logic [swa_pkg::CFG_W-1:0]    clamp_w;
  logic [CNT_W-1:0]             slot_inc;
  logic [swa_pkg::SAMPLE_W-1:0] old_sample;
  logic [CNT_W:0]               rem_sh;
  logic                         rem_ge;

  // window clamp: zero becomes one, above the maximum becomes the maximum
  always_comb begin
    if (cfg_window_size == '0) begin
      clamp_w = swa_pkg::CFG_W'(1);
    end else if (cfg_window_size > swa_pkg::CFG_W'(WINDOW_MAX)) begin
      clamp_w = swa_pkg::CFG_W'(WINDOW_MAX);
    end else begin
      clamp_w = cfg_window_size;
    end
    window_nxt = clamp_w[CNT_W-1:0];
  end

  // until the window has filled, the slot being overwritten holds no sample
  always_comb begin
    old_sample = (count_r == window_r) ? rd_data_r : '0;
    sum_nxt    = sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);
    slot_inc   = CNT_W'(slot_r) + CNT_W'(1);
    slot_nxt   = (slot_inc >= window_r) ? '0 : slot_inc[IDX_W-1:0];
    count_nxt  = (count_r < window_r) ? count_r + CNT_W'(1) : count_r;
  end

  // restoring divider, one quotient bit per step
  always_comb begin
    rem_sh = {rem_r, quot_r[DW-1]};
    rem_ge = rem_sh >= {1'b0, count_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      count_r  <= '0;
      slot_r   <= '0;
      sum_r    <= '0;
    end else if (cmd.cfg_write) begin
      window_r <= window_nxt;
      count_r  <= '0;
      slot_r   <= '0;
      sum_r    <= '0;
    end else if (cmd.update) begin
      count_r <= count_nxt;
      slot_r  <= slot_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // ring memory with registered read at the current slot
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      ring[slot_r] <= sample_r;
    end
    rd_data_r <= ring[slot_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_sample) begin
      sample_r <= in_sample;
    end
    if (cmd.pass_load) begin
      quot_r <= DW'({in_sample, swa_pkg::FRAC_W'(0)});
    end else if (cmd.update) begin
      quot_r <= {sum_nxt, swa_pkg::FRAC_W'(0)};
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      quot_r <= {quot_r[DW-2:0], rem_ge};
      rem_r  <= rem_ge ? CNT_W'(rem_sh - {1'b0, count_r}) : rem_sh[CNT_W-1:0];
      step_r <= step_r + STEP_W'(1);
    end
    if (cmd.load_out) begin
      avg_r  <= quot_r[swa_pkg::AVG_W-1:0];
      fill_r <= swa_pkg::FILL_W'(count_r);
    end
  end

  assign sts.pass_mode  = (window_r == '0);
  assign sts.div_last   = (step_r == STEP_W'(DW - 1));
  assign out_average_q8 = avg_r;
  assign out_fill_count = fill_r;

  `SWA_ASSERT_NOW(a_count_in_window, clk, rst_n, 1'b1, count_r <= window_r)
  `SWA_ASSERT_NOW(a_window_max, clk, rst_n, 1'b1, window_r <= CNT_W'(WINDOW_MAX))
  `SWA_ASSERT_NOW(a_slot_in_window, clk, rst_n,
    window_r != '0, CNT_W'(slot_r) < window_r)

endmodule

/* rtl/core/sliding_window_average_u16.sv */
// sliding-window mean of unsigned 16-bit samples
//
// channels: in_valid/in_ready carry one sample request, out_valid/out_ready
// carry one result request (out_average_q8 = mean with 8 fraction bits,
// truncated; out_fill_count = samples now in the window). cfg_valid/cfg_ready
// write the window size, clamped to 1..WINDOW_MAX; a write restarts the window.
// config requests are taken only while no sample is in flight.
// sequence: a sample is accepted, then the ring/sum update runs, then the
// restoring divider, which produces one quotient bit per cycle, and then the
// result is loaded into the output register; one sample is in flight at a
// time. before the first window write the block passes samples straight
// through (sample * 256, fill count 0), skipping the update and the division.
// reset: window size 0 (pass-through), sum, slot and count cleared; ring
// contents are not cleared, the fill count marks which slots hold samples.
// receiver stall: the result waits in the output register; a new sample is
// still accepted and computed, then waits until the held result is taken.
module sliding_window_average_u16 #(
  parameter int WINDOW_MAX = swa_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [swa_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [swa_pkg::AVG_W-1:0]    out_average_q8,
  output logic [swa_pkg::FILL_W-1:0]   out_fill_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [swa_pkg::CFG_W-1:0]    cfg_window_size
);

  swa_pkg::cmd_t    cmd;
  swa_pkg::status_t sts;

  // sequencing: accept, ring/sum update, division steps, output handoff
  swa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // ring memory, running sum, divider and output register
  swa_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_sample       (in_sample),
    .cfg_window_size (cfg_window_size),
    .cmd             (cmd),
    .sts             (sts),
    .out_average_q8  (out_average_q8),
    .out_fill_count  (out_fill_count)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  // generous: well above the slowest correct run, holds included
  localparam int CYCLE_LIMIT  = 1000000;
  // more than one sample's latency through the divider
  localparam int DRAIN_CYCLES = 60;
  // long receiver hold-off, long enough for the block to back up
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 150;
  localparam int TAIL_ITEMS   = 230;
  localparam int SLOT_W       = $clog2(swa_pkg::WINDOW_MAX_DEF);

  typedef struct packed {
    logic [swa_pkg::AVG_W-1:0]  average_q8;
    logic [swa_pkg::FILL_W-1:0] fill_count;
  } mean_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // block inputs, all known from time zero
  logic                         in_valid        = 1'b0;
  logic                         in_ready;
  logic [swa_pkg::SAMPLE_W-1:0] in_sample       = '0;
  logic                         out_valid;
  logic                         out_ready       = 1'b0;
  logic [swa_pkg::AVG_W-1:0]    out_average_q8;
  logic [swa_pkg::FILL_W-1:0]   out_fill_count;
  logic                         cfg_valid       = 1'b0;
  logic                         cfg_ready;
  logic [swa_pkg::CFG_W-1:0]    cfg_window_size = '0;

  sliding_window_average_u16 u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average_q8 (out_average_q8),
    .out_fill_count (out_fill_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_window_size(cfg_window_size)
  );

  // ---------------------------------------------------------------------------
  // mean predictor: own copy of the window store and the window size
  // ---------------------------------------------------------------------------
  logic [swa_pkg::SAMPLE_W-1:0] win_ring [swa_pkg::WINDOW_MAX_DEF];
  logic [20:0]                  win_sum   = '0;
  logic [SLOT_W-1:0]            win_slot  = '0;
  int unsigned                  win_count = 0;
  int unsigned                  win_size  = 0;   // 0 until the first write: pass-through

  initial begin
    win_ring = '{default: '0};
  end

  // clamp to 1..max, then restart the window
  task automatic apply_window(input logic [swa_pkg::CFG_W-1:0] value);
    int unsigned w;
    w = 32'(value);
    if (w == 0) w = 1;
    else if (w > swa_pkg::WINDOW_MAX_DEF) w = swa_pkg::WINDOW_MAX_DEF;
    win_size  = w;
    win_ring  = '{default: '0};
    win_sum   = '0;
    win_slot  = '0;
    win_count = 0;
  endtask

  task automatic predict_mean(input logic [swa_pkg::SAMPLE_W-1:0] s, output mean_t r);
    logic [31:0] scaled;
    logic [31:0] quot;
    if (win_size == 0) begin
      // pass-through: the store is left alone
      r.average_q8 = {s, 8'h00};
      r.fill_count = win_count[swa_pkg::FILL_W-1:0];
    end else begin
      win_sum = win_sum - 21'(win_ring[win_slot]) + 21'(s);
      win_ring[win_slot] = s;
      if (32'(win_slot) + 32'd1 >= win_size) win_slot = '0;
      else win_slot = win_slot + SLOT_W'(1);
      if (win_count < win_size) win_count = win_count + 1;
      scaled = {11'b0, win_sum} << swa_pkg::FRAC_W;
      quot   = scaled / win_count;
      r.average_q8 = quot[swa_pkg::AVG_W-1:0];
      r.fill_count = win_count[swa_pkg::FILL_W-1:0];
    end
  endtask

  // ---------------------------------------------------------------------------
  // shared bookkeeping
  // ---------------------------------------------------------------------------
  logic [swa_pkg::SAMPLE_W-1:0] sample_backlog [$];   // samples waiting to be offered
  mean_t                        pending_means  [$];   // results owed by the block

  int unsigned cycle_cnt    = 0;
  int unsigned tx_sent      = 0;   // sample requests put on the bus
  int unsigned tx_taken     = 0;   // sample requests accepted
  int unsigned cfg_taken    = 0;   // window writes accepted
  int unsigned rx_checked   = 0;   // results compared
  int unsigned err_cnt      = 0;
  bit          quiet_tail   = 1'b0; // last stretch: no idling at all
  bit          rx_hold_req  = 1'b0; // toggled to ask for a long receiver hold
  bit          rx_hold_ack  = 1'b0;

  // ---------------------------------------------------------------------------
  // sample driver: inputs move at the falling edge
  // ---------------------------------------------------------------------------
  int unsigned tx_gap = 0;

  always @(negedge clk) begin
    if (in_valid && tx_sent != tx_taken) begin
      // request still outstanding: hold valid and payload
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap   <= tx_gap - 1;
    end else if (rst_n && sample_backlog.size() > 0) begin
      in_valid  <= 1'b1;
      in_sample <= sample_backlog.pop_front();
      tx_sent   <= tx_sent + 1;
      // idle burst after this request is taken
      if (!quiet_tail && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 10);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls, plus the long hold-off on request
  // ---------------------------------------------------------------------------
  int unsigned rx_gap  = 0;
  int unsigned rx_long = 0;

  always @(negedge clk) begin
    if (rx_long > 0) begin
      out_ready <= 1'b0;
      rx_long   <= rx_long - 1;
      if (rx_long == 1) rx_hold_ack <= rx_hold_req;
    end else if (rx_hold_req != rx_hold_ack) begin
      out_ready <= 1'b0;
      rx_long   <= LONG_HOLD;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap    <= rx_gap - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet_tail && $urandom_range(0, 7) == 0) rx_gap <= $urandom_range(1, 10);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: everything sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    mean_t want;
    mean_t got;
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_cnt, pending_means.size());
      $display("Verification failed");
      $finish;
    end else if (rst_n) begin
      // check the result first, so a request taken on this edge cannot cover
      // a result that nobody asked for
      if (out_valid && out_ready) begin
        got.average_q8 = out_average_q8;
        got.fill_count = out_fill_count;
        rx_checked = rx_checked + 1;
        if (pending_means.size() == 0) begin
          if (err_cnt < 10)
            $display("unexpected result at cycle %0d: avg %0d fill %0d",
                     cycle_cnt, got.average_q8, got.fill_count);
          err_cnt = err_cnt + 1;
        end else begin
          want = pending_means.pop_front();
          if (got !== want) begin
            if (err_cnt < 10)
              $display("mismatch at cycle %0d: avg exp %0d got %0d, fill exp %0d got %0d",
                       cycle_cnt, want.average_q8, got.average_q8,
                       want.fill_count, got.fill_count);
            err_cnt = err_cnt + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_mean(in_sample, want);
        pending_means.push_back(want);
        tx_taken = tx_taken + 1;
      end
      if (cfg_valid && cfg_ready) begin
        apply_window(cfg_window_size);
        cfg_taken = cfg_taken + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // block idle: nothing queued, nothing on the bus, nothing owed
  task automatic wait_idle();
    while (!(sample_backlog.size() == 0 && tx_sent == tx_taken &&
             pending_means.size() == 0))
      @(negedge clk);
  endtask

  // window write, only once the block has drained
  task automatic write_window(input logic [swa_pkg::CFG_W-1:0] value);
    int unsigned seen;
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    seen = cfg_taken;
    cfg_valid       <= 1'b1;
    cfg_window_size <= value;
    do @(negedge clk); while (cfg_taken == seen);
    cfg_valid <= 1'b0;
  endtask

  // mostly uniform, with weight on the edges and on large values that
  // push the running sum toward its top
  function automatic logic [swa_pkg::SAMPLE_W-1:0] pick_sample();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 6) return swa_pkg::SAMPLE_W'($urandom_range(0, 16'hFFFF));
    else if (k < 8) return 16'hFFFF - swa_pkg::SAMPLE_W'($urandom_range(0, 15));
    else if (k == 8) return swa_pkg::SAMPLE_W'($urandom_range(0, 15));
    else return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
  endfunction

  initial begin
    logic [swa_pkg::CFG_W-1:0] phase_win [$];
    int unsigned               win_writes;
    win_writes = 0;
    // window settings for the random phases: extremes and clamps included
    phase_win = '{8'd32, 8'd1, 8'd33, 8'd3, 8'd31, 8'd0, 8'd255, 8'd2, 8'd0, 8'd0};
    phase_win[8] = swa_pkg::CFG_W'($urandom_range(0, 255));
    phase_win[9] = swa_pkg::CFG_W'($urandom_range(1, 40));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pass-through before any window write: sample * 256, fill count 0
    sample_backlog = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'hA5A5};
    wait_idle();

    // write of zero clamps to a window of one
    write_window(8'd0);
    win_writes++;
    sample_backlog = '{16'hFFFF, 16'h0000, 16'h0003};
    wait_idle();

    // window of two: wrap of the write slot after two samples
    write_window(8'd2);
    win_writes++;
    sample_backlog = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001};
    wait_idle();

    // write above the maximum clamps to the maximum
    write_window(8'd255);
    win_writes++;
    sample_backlog = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001};
    wait_idle();

    // random phases, each restarted by a window write
    for (int p = 0; p < phase_win.size(); p++) begin
      write_window(phase_win[p]);
      win_writes++;
      for (int i = 0; i < PHASE_ITEMS; i++) sample_backlog.push_back(pick_sample());
      if (p == 3) begin
        // receiver goes quiet while the sender keeps offering: the block fills
        // its output register and then stalls the input
        rx_hold_req = ~rx_hold_req;
        while (rx_hold_req != rx_hold_ack) @(negedge clk);
      end
      // sender pauses here until every owed result is in
      wait_idle();
    end

    // last stretch at full rate on both sides
    quiet_tail = 1'b1;
    write_window(swa_pkg::CFG_W'($urandom_range(1, swa_pkg::WINDOW_MAX_DEF)));
    win_writes++;
    for (int i = 0; i < TAIL_ITEMS; i++) sample_backlog.push_back(pick_sample());
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d samples across pass-through and %0d window settings",
             tx_taken, win_writes);
    $display("%0d results compared, %0d mismatches, %0d cycles",
             rx_checked, err_cnt, cycle_cnt);
    if (err_cnt == 0 && pending_means.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/swa_pkg.sv
rtl/core/swa_ctrl.sv
rtl/core/swa_dp.sv
rtl/core/sliding_window_average_u16.sv
tb/sv/tb_top.sv
